>>> rtl/core/glmd_pkg.sv
// Package for the group loss mean and deviation block.
// Holds the shared types, row codes and the close job record.
// No dependencies.
`timescale 1ns / 1ps

package glmd_pkg;

  localparam int unsigned IdBits   = 31;
  localparam int unsigned ExpBits  = 32;
  localparam int unsigned QBits    = 35;
  localparam int unsigned SumBits  = 37;
  localparam int unsigned SqBits   = 64;
  localparam int unsigned NBits    = 11;
  localparam int unsigned FracBits = 8;
  localparam logic [23:0] TinyScale = 24'd10000000;

  typedef enum logic [1:0] {
    ROW_NONE     = 2'd0,
    ROW_ANALYTIC = 2'd1,
    ROW_SAMPLED  = 2'd2
  } row_type_t;

  // One closed group handed from the front end to the back end.
  typedef struct packed {
    logic [IdBits-1:0]  summary_key;
    logic [IdBits-1:0]  event_key;
    logic [ExpBits-1:0] exposure;
    logic [SumBits-1:0] loss_sum;
    logic [SqBits-1:0]  square_sum;
    logic [26:0]        analytic_mean;
    logic [NBits-1:0]   n;
  } close_job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_MEAN_DIV,
    ST_CHECK,
    ST_VAR_DIV,
    ST_SQRT,
    ST_ROW1,
    ST_ROW2
  } back_state_t;

endpackage

>>> rtl/core/glmd_front.sv
// Front end: accepts headers and sample records and keeps the running sums.
// A close with nonzero exposure pushes one close job. Depends on glmd_pkg.
`timescale 1ns / 1ps

module glmd_front #(
  parameter int unsigned LOSS_BITS   = 27,
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       mode,
  input  logic [30:0]                summary_key,
  input  logic [30:0]                event_key,
  input  logic [31:0]                exposure,
  input  logic signed [11:0]         sample_index,
  input  logic [26:0]                loss,
  input  logic [10:0]                sample_size,
  output logic                       job_valid,
  input  logic                       job_ready,
  output glmd_pkg::close_job_t       job
);
  import glmd_pkg::*;

  logic [IdBits-1:0]    held_summary;
  logic [IdBits-1:0]    held_event;
  logic [ExpBits-1:0]   held_exposure;
  logic [SumBits-1:0]   loss_sum;
  logic [SqBits-1:0]    loss_square_sum;
  logic [26:0]          analytic_mean;
  logic [26:0]          loss_m;
  logic [53:0]          loss_sq;
  logic                 accept;
  logic                 is_close;
  logic [NBits-1:0]     n_sat;

  assign in_ready = !job_valid || job_ready;
  assign accept   = in_valid && in_ready;
  assign loss_m   = loss & 27'((64'd1 << LOSS_BITS) - 64'd1);
  assign loss_sq  = 54'(loss_m) * 54'(loss_m);
  assign is_close = mode && (sample_index == 12'sd0);
  assign n_sat    = (sample_size > NBits'(MAX_SAMPLES)) ? NBits'(MAX_SAMPLES) : sample_size;

  // Running state of the open group.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_summary    <= '0;
      held_event      <= '0;
      held_exposure   <= '0;
      loss_sum        <= '0;
      loss_square_sum <= '0;
      analytic_mean   <= '0;
    end else if (accept) begin
      if (!mode) begin
        held_summary  <= summary_key;
        held_event    <= event_key;
        held_exposure <= exposure;
      end else if (sample_index == -12'sd1) begin
        analytic_mean <= loss_m;
      end else if (sample_index == 12'sd0) begin
        loss_sum        <= '0;
        loss_square_sum <= '0;
        analytic_mean   <= '0;
      end else if (sample_index > 12'sd0) begin
        loss_sum        <= loss_sum + SumBits'(loss_m);
        loss_square_sum <= loss_square_sum + SqBits'(loss_sq);
      end
    end
  end

  // One-entry queue toward the back end; groups with zero exposure drop here.
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (accept && is_close && held_exposure != '0) begin
      job_valid <= 1'b1;
    end else if (job_ready) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_close) begin
      job.summary_key   <= held_summary;
      job.event_key     <= held_event;
      job.exposure      <= held_exposure;
      job.loss_sum      <= loss_sum;
      job.square_sum    <= loss_square_sum;
      job.analytic_mean <= analytic_mean;
      job.n             <= n_sat;
    end
  end

endmodule

>>> rtl/core/glmd_back.sv
// Back end: turns a close job into rows, with a bit-serial divider and
// square root. Depends on glmd_pkg.
`timescale 1ns / 1ps

module glmd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  glmd_pkg::close_job_t job,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           row_type,
  output logic [30:0]          out_summary_key,
  output logic [30:0]          out_event_key,
  output logic [34:0]          mean_loss,
  output logic [34:0]          deviation,
  output logic [31:0]          out_exposure,
  output logic                 last
);
  import glmd_pkg::*;

  back_state_t state, state_next;
  close_job_t  cur;
  logic [6:0]   step;
  logic [21:0]  nn1;
  // Shared multiplier operands and its registered product.
  logic [31:0]  ma;
  logic [31:0]  mb;
  logic [63:0]  prod;
  logic [3:0]   mphase;
  logic [127:0] a_term;
  logic [127:0] b_term;
  logic [127:0] dvar;
  logic [127:0] lhs;
  logic [127:0] rhs;
  // Restoring divider: quotient shifts in, remainder stays below the divisor.
  logic [127:0] quo;
  logic [22:0]  rem;
  logic [22:0]  rem_sh;
  logic [21:0]  divisor;
  // Square root by restoring digit pairs.
  logic [63:0]  root;
  logic [65:0]  srem;
  logic [65:0]  strial;
  logic [127:0] sval;
  logic [34:0]  mean_q;
  logic [34:0]  dev_q;
  logic         dev_zero;

  assign job_ready = (state == ST_IDLE);
  assign rem_sh    = {rem[21:0], quo[127]};
  assign strial    = {srem[63:0], sval[127:126]} - {root, 2'b01};

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (job_valid) state_next = ST_ROW1;
      ST_ROW1:     if (out_ready) state_next = (cur.n == '0) ? ST_IDLE : ST_MEAN_DIV;
      ST_MEAN_DIV: if (step == 7'd127) state_next = (cur.n > 11'd1) ? ST_MUL : ST_ROW2;
      ST_MUL:      if (mphase == 4'd10) state_next = ST_CHECK;
      ST_CHECK:    state_next = dev_zero ? ST_ROW2 : ST_VAR_DIV;
      ST_VAR_DIV:  if (step == 7'd127) state_next = ST_SQRT;
      ST_SQRT:     if (step == 7'd63) state_next = ST_ROW2;
      ST_ROW2:     if (out_ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Outputs.
  always_comb begin
    out_valid = 1'b0;
    row_type  = ROW_NONE;
    mean_loss = '0;
    deviation = '0;
    last      = 1'b0;
    unique case (state)
      ST_ROW1: begin
        out_valid = 1'b1;
        row_type  = ROW_ANALYTIC;
        mean_loss = {cur.analytic_mean, 8'd0};
        last      = (cur.n == '0);
      end
      ST_ROW2: begin
        out_valid = 1'b1;
        row_type  = ROW_SAMPLED;
        mean_loss = mean_q;
        deviation = dev_q;
        last      = 1'b1;
      end
      default: ;
    endcase
  end
  assign out_summary_key = cur.summary_key;
  assign out_event_key   = cur.event_key;
  assign out_exposure    = cur.exposure;

  // Multiplier schedule, one 32x32 partial product per cycle:
  // phases 0-1 sumsq*n, 2-4 sum*sum, 5-6 sumsq*nn1, 7-9 D*1e7.
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (mphase)
      4'd0: begin ma = cur.square_sum[31:0];  mb = 32'(cur.n); end
      4'd1: begin ma = cur.square_sum[63:32]; mb = 32'(cur.n); end
      4'd2: begin ma = cur.loss_sum[31:0];    mb = cur.loss_sum[31:0]; end
      4'd3: begin ma = cur.loss_sum[31:0];    mb = 32'(cur.loss_sum[36:32]); end
      4'd4: begin
        ma = 32'(cur.loss_sum[36:32]);
        mb = 32'(cur.loss_sum[36:32]);
      end
      4'd5: begin ma = cur.square_sum[31:0];  mb = 32'(nn1); end
      4'd6: begin ma = cur.square_sum[63:32]; mb = 32'(nn1); end
      4'd7: begin ma = dvar[31:0];  mb = 32'(TinyScale); end
      4'd8: begin ma = dvar[63:32]; mb = 32'(TinyScale); end
      4'd9: begin ma = dvar[95:64]; mb = 32'(TinyScale); end
      default: ;
    endcase
  end

  assign dev_zero = (a_term < b_term) || (lhs < rhs);

  // Datapath.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && job_valid) begin
      cur    <= job;
      nn1    <= 22'(job.n) * 22'(job.n - 11'd1);
      step   <= '0;
      mphase <= '0;
      mean_q <= '0;
      dev_q  <= '0;
    end
    prod <= 64'(ma) * 64'(mb);
    unique case (state)
      ST_ROW1: begin
        quo     <= 128'({cur.loss_sum, 8'd0});
        rem     <= '0;
        divisor <= 22'(cur.n);
        step    <= '0;
      end
      ST_MEAN_DIV, ST_VAR_DIV: begin
        if (rem_sh >= 23'(divisor)) begin
          rem <= rem_sh - 23'(divisor);
          quo <= {quo[126:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[126:0], 1'b0};
        end
        step <= step + 7'd1;
        if (state == ST_MEAN_DIV && step == 7'd127) begin
          mean_q <= (({quo[126:0], 1'b0} >> 35) != '0 ||
                     (rem_sh >= 23'(divisor) && 1'b0)) ? '1 :
                    ((rem_sh >= 23'(divisor)) ? 35'({quo[126:0], 1'b1})
                                               : 35'({quo[126:0], 1'b0}));
          mphase <= '0;
        end
        // The step count wraps to zero here, ready for the square root.
        if (state == ST_VAR_DIV && step == 7'd127) begin
          sval <= (rem_sh >= 23'(divisor)) ? {quo[126:0], 1'b1} : {quo[126:0], 1'b0};
          root <= '0;
          srem <= '0;
        end
      end
      ST_MUL: begin
        mphase <= mphase + 4'd1;
        // Each partial product lands from the registered product in the phase after its own.
        unique case (mphase)
          4'd1:  a_term <= 128'(prod);
          4'd2:  a_term <= a_term + (128'(prod) << 32);
          4'd3:  b_term <= 128'(prod);
          4'd4:  b_term <= b_term + (128'(prod) << 33);
          4'd5:  b_term <= b_term + (128'(prod) << 64);
          4'd6: begin
            rhs  <= 128'(prod);
            dvar <= a_term - b_term;
          end
          4'd7:  rhs <= rhs + (128'(prod) << 32);
          4'd8:  lhs <= 128'(prod);
          4'd9:  lhs <= lhs + (128'(prod) << 32);
          4'd10: lhs <= lhs + (128'(prod) << 64);
          default: ;
        endcase
      end
      ST_CHECK: begin
        quo     <= {dvar[111:0], 16'd0};
        rem     <= '0;
        divisor <= nn1;
        step    <= '0;
      end
      ST_SQRT: begin
        sval <= {sval[125:0], 2'b00};
        if (!strial[65]) begin
          srem <= strial;
          root <= {root[62:0], 1'b1};
        end else begin
          srem <= {srem[63:0], sval[127:126]};
          root <= {root[62:0], 1'b0};
        end
        step <= step + 7'd1;
        if (step == 7'd63) begin
          dev_q <= (root[63:34] != '0) ? '1 :
                   {root[33:0], ~strial[65]};
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/group_loss_mean_and_deviation.sv
// Top level of the group loss mean and deviation block.
// Instantiates glmd_front and glmd_back; depends on glmd_pkg.
`timescale 1ns / 1ps

// Headers and sample records are taken one per cycle by the front end. A
// closing record hands its group to the back end through a one-entry queue.
// With two or more samples and a nonzero deviation, the back end takes the
// job, sends the type-1 row, runs the mean division, the partial products,
// the checks, the variance division and the square root, and sends the
// type-2 row; the bit-serial divider and root unit set its pace. It takes no
// new job until its last row is out. A further close waits in the queue and
// records stall once the queue is full and the back end busy.
module group_loss_mean_and_deviation #(
  parameter int unsigned MAX_SAMPLES = 1024,
  parameter int unsigned LOSS_BITS   = 27
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: summary key, event key, exposure, sample_index, loss, then zero fill.
  input  logic [135:0] s_axis_tdata,
  // tuser: mode.
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: summary key, event key, mean_loss, deviation, out_exposure, zero fill.
  output logic [167:0] m_axis_tdata,
  // tuser: row_type.
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         cfg_we,
  input  logic [10:0]  cfg_wdata
);
  import glmd_pkg::*;

  logic [10:0] sample_size;
  logic        job_valid;
  logic        job_ready;
  close_job_t  job;
  logic [30:0] o_sum;
  logic [30:0] o_evt;
  logic [34:0] o_mean;
  logic [34:0] o_dev;
  logic [31:0] o_exp;

  // Sample size register.
  always_ff @(posedge clk) begin
    if (rst)         sample_size <= '0;
    else if (cfg_we) sample_size <= cfg_wdata;
  end

  glmd_front #(.LOSS_BITS(LOSS_BITS), .MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .mode(s_axis_tuser),
    .summary_key(s_axis_tdata[30:0]), .event_key(s_axis_tdata[61:31]),
    .exposure(s_axis_tdata[93:62]), .sample_index(s_axis_tdata[105:94]),
    .loss(s_axis_tdata[132:106]),
    .sample_size, .job_valid, .job_ready, .job
  );

  glmd_back u_back (
    .clk, .rst, .job_valid, .job_ready, .job,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .row_type(m_axis_tuser), .out_summary_key(o_sum), .out_event_key(o_evt),
    .mean_loss(o_mean), .deviation(o_dev), .out_exposure(o_exp), .last(m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, o_exp, o_dev, o_mean, o_evt, o_sum};

endmodule
